// ===== design/steq_pkg.sv =====
// Shared constants, types and helpers of the sorted timer event queue.
package steq_pkg;

   // Sizing
   localparam int QUEUE_DEPTH = 32;
   localparam int TIME_BITS   = 48;
   localparam int HANDLE_BITS = 16;
   localparam int MAX_RESULTS = 32;

   // Ring index and entry count widths
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Command codes
   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_FULL     = 2'd1;
   localparam logic [1:0] KIND_RELEASED = 2'd2;
   localparam logic [1:0] KIND_NONE_DUE = 2'd3;

   typedef logic [TIME_BITS-1:0]   time_type;
   typedef logic [HANDLE_BITS-1:0] handle_type;
   typedef logic [IDX_W-1:0]       index_type;
   typedef logic [CNT_W-1:0]       count_type;

   // One stored queue entry
   typedef struct packed {
      time_type   event_time;
      handle_type handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Status from the controller to the top level
   typedef struct packed {
      logic      idle;
      count_type count;
   } status_type;

   // Physical ring address of logical slot off, counted from base
   function automatic index_type ring_index(input index_type base, input count_type off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== design/steq_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module steq_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/steq_ctrl.sv =====
// Sequencer of the timer queue: insertion scan, tick release and result register.
module steq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  steq_pkg::time_type        req_event_time,
   input  steq_pkg::handle_type      req_handle,
   // Result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output steq_pkg::handle_type      rsp_handle_out,
   output steq_pkg::time_type        rsp_time_out,
   output logic                      rsp_became_first,
   output logic                      rsp_last,
   // Entry RAM
   output logic                      ram_wr_en,
   output steq_pkg::index_type       ram_wr_addr,
   output steq_pkg::entry_type       ram_wr_data,
   output logic                      ram_rd_en,
   output steq_pkg::index_type       ram_rd_addr,
   input  steq_pkg::entry_type       ram_rd_data,
   // Status
   output steq_pkg::status_type      status
);

   import steq_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INS      = 3'd1;
   localparam logic [2:0] S_INS_CMP  = 3'd2;
   localparam logic [2:0] S_TICK     = 3'd3;
   localparam logic [2:0] S_TICK_CMP = 3'd4;
   localparam logic [2:0] S_TICK_END = 3'd5;

   logic [2:0] state_ff, state_in;
   index_type  head_ff, head_in;
   count_type  count_ff, count_in;
   count_type  pos_ff, pos_in;
   time_type   time_ff, time_in;
   handle_type handle_ff, handle_in;
   logic       held_valid_ff, held_valid_in;
   entry_type  held_ff, held_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   handle_type rsp_handle_ff, rsp_handle_in;
   time_type   rsp_time_ff, rsp_time_in;
   logic       first_ff, first_in;
   logic       last_ff, last_in;

   logic       emit;
   logic       out_free;
   logic       rd_due;
   logic       scan_more;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_due    = (ram_rd_data.event_time <= time_ff);
   assign scan_more = (pos_ff < count_ff) && (32'(pos_ff) < MAX_RESULTS);

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      time_in       = time_ff;
      handle_in     = handle_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      emit          = 1'b0;
      kind_in       = kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_time_in   = rsp_time_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               time_in       = req_event_time;
               handle_in     = req_handle;
               held_valid_in = 1'b0;
               if (req_cmd == CMD_SCHEDULE) begin
                  pos_in   = count_ff;
                  state_in = S_INS;
               end else begin
                  pos_in   = '0;
                  state_in = S_TICK;
               end
            end
         end

         // Walk down from the tail; pos is the free slot
         S_INS: begin
            if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
               if (out_free) begin
                  emit          = 1'b1;
                  kind_in       = KIND_FULL;
                  rsp_handle_in = handle_ff;
                  rsp_time_in   = time_ff;
                  first_in      = 1'b0;
                  last_in       = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (pos_ff == '0) begin
               if (out_free) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = head_ff;
                  ram_wr_data   = '{event_time: time_ff, handle: handle_ff};
                  count_in      = count_ff + CNT_W'(1);
                  emit          = 1'b1;
                  kind_in       = KIND_ACCEPTED;
                  rsp_handle_in = handle_ff;
                  rsp_time_in   = time_ff;
                  first_in      = 1'b1;
                  last_in       = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_index(head_ff, pos_ff - CNT_W'(1));
               state_in    = S_INS_CMP;
            end
         end

         // Entry below the free slot is in; stop or move it up
         S_INS_CMP: begin
            if (rd_due) begin
               if (out_free) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = ring_index(head_ff, pos_ff);
                  ram_wr_data   = '{event_time: time_ff, handle: handle_ff};
                  count_in      = count_ff + CNT_W'(1);
                  emit          = 1'b1;
                  kind_in       = KIND_ACCEPTED;
                  rsp_handle_in = handle_ff;
                  rsp_time_in   = time_ff;
                  first_in      = 1'b0;
                  last_in       = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = ring_index(head_ff, pos_ff);
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - CNT_W'(1);
               state_in    = S_INS;
            end
         end

         // Fetch the next candidate from the head side
         S_TICK: begin
            if (scan_more) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_index(head_ff, pos_ff);
               state_in    = S_TICK_CMP;
            end else begin
               state_in = S_TICK_END;
            end
         end

         // A due candidate is held, and frees any entry held before it as a non-final word
         S_TICK_CMP: begin
            if (!rd_due) begin
               state_in = S_TICK_END;
            end else if (!held_valid_ff) begin
               held_in       = ram_rd_data;
               held_valid_in = 1'b1;
               pos_in        = pos_ff + CNT_W'(1);
               state_in      = S_TICK;
            end else if (out_free) begin
               emit          = 1'b1;
               kind_in       = KIND_RELEASED;
               rsp_handle_in = held_ff.handle;
               rsp_time_in   = held_ff.event_time;
               first_in      = 1'b0;
               last_in       = 1'b0;
               held_in       = ram_rd_data;
               pos_in        = pos_ff + CNT_W'(1);
               state_in      = S_TICK;
            end
         end

         // Final word of the tick, then drop released entries
         S_TICK_END: begin
            if (out_free) begin
               emit     = 1'b1;
               first_in = 1'b0;
               last_in  = 1'b1;
               state_in = S_IDLE;
               if (held_valid_ff) begin
                  kind_in       = KIND_RELEASED;
                  rsp_handle_in = held_ff.handle;
                  rsp_time_in   = held_ff.event_time;
                  head_in       = ring_index(head_ff, pos_ff);
                  count_in      = count_ff - pos_ff;
               end else begin
                  kind_in       = KIND_NONE_DUE;
                  rsp_handle_in = '0;
                  rsp_time_in   = time_ff;
               end
               held_valid_in = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      time_ff       <= time_in;
      handle_ff     <= handle_in;
      held_ff       <= held_in;
      kind_ff       <= kind_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_time_ff   <= rsp_time_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_handle_out   = rsp_handle_ff;
   assign rsp_time_out     = rsp_time_ff;
   assign rsp_became_first = first_ff;
   assign rsp_last         = last_ff;

   assign status.idle  = (state_ff == S_IDLE);
   assign status.count = count_ff;

endmodule

// ===== design/sorted_timer_event_queue_top.sv =====
// Top level of the sorted timer event queue: controller, entry RAM and checks.
//
// Pending entries live in a ring in one synchronous RAM, kept sorted by due
// time, with a head pointer and a count. A schedule word runs an insertion
// scan from the tail that moves every stored entry with a later time up one
// slot through the single RAM read port, reading each entry and then writing
// it back; no scan runs when the queue is full. A tick word reads entries
// from the head, releasing each due one, and stops on an entry not yet due,
// at the count or at the release limit; release only advances the head
// pointer. A result word that waits for the receiver stalls the sequencer.
// A new word is taken once the previous one has placed its final result in
// the output register. Entry contents are undefined after reset; only the
// count and the head pointer are cleared, so no clearing pass runs.
module sorted_timer_event_queue_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  steq_pkg::time_type    req_event_time,
   input  steq_pkg::handle_type  req_handle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output steq_pkg::handle_type  rsp_handle_out,
   output steq_pkg::time_type    rsp_time_out,
   output logic                  rsp_became_first,
   output logic                  rsp_last
);

   import steq_pkg::*;

   logic       ram_wr_en;
   index_type  ram_wr_addr;
   entry_type  ram_wr_data;
   logic       ram_rd_en;
   index_type  ram_rd_addr;
   entry_type  ram_rd_data;
   status_type status;

   // Sequencer
   steq_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_event_time   (req_event_time),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_time_out     (rsp_time_out),
      .rsp_became_first (rsp_became_first),
      .rsp_last         (rsp_last),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .status           (status)
   );

   // Entry storage
   steq_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Queue never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(status.count) <= QUEUE_DEPTH)
      else $error("entry count above queue depth");

   // Only released entries may be non-final words
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_RELEASED) |-> rsp_last)
      else $error("single-word result not marked last");

   // Became-first only on accepted schedules
   a_first_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_became_first |-> (rsp_kind == KIND_ACCEPTED))
      else $error("became_first on a non-accepted result");

   // A taken word leaves the sequencer busy in the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !status.idle)
      else $error("sequencer idle right after taking a word");

endmodule

// ===== verif/sorted_timer_event_queue_top_tb.sv =====
// Testbench of the sorted timer event queue: scoreboard, drivers, stimulus and checks.
`timescale 1ns / 100ps

module sorted_timer_event_queue_top_tb;
   import steq_pkg::*;

   localparam time_type TIME_MAX    = {{(TIME_BITS-1){1'b1}}, 1'b0};
   localparam int       CYCLE_LIMIT = 600000;
   localparam int       LONG_STALL  = 300;
   localparam int       SETTLE      = 150;
   localparam int       PHASE_WORDS = 78;

   // One result word as seen on the rsp_ channel
   typedef struct packed {
      logic [1:0] kind;
      handle_type handle;
      time_type   due;
      logic       became_first;
      logic       is_last;
   } rsp_word_type;

   // Keeps its own sorted copy of the pending entries and the results still owed
   class timer_queue_scoreboard;
      entry_type    pending_entries[$];
      rsp_word_type owed_results[$];
      int           errors = 0;

      function int outstanding();
         return owed_results.size();
      endfunction

      // Work out the results of one accepted request word
      function void note_request(logic cmd, time_type t, handle_type h);
         int           pos;
         int           due_count;
         entry_type    e;
         rsp_word_type w;
         if (cmd == CMD_SCHEDULE) begin
            if (pending_entries.size() >= QUEUE_DEPTH) begin
               w = '{KIND_FULL, h, t, 1'b0, 1'b1};
            end else begin
               // insert behind every entry due at or before t, so ties stay in order
               pos = 0;
               while (pos < pending_entries.size() && pending_entries[pos].event_time <= t) begin
                  pos++;
               end
               e.event_time = t;
               e.handle     = h;
               pending_entries.insert(pos, e);
               w = '{KIND_ACCEPTED, h, t, (pos == 0), 1'b1};
            end
            owed_results.insert(owed_results.size(), w);
         end else begin
            due_count = 0;
            while (due_count < pending_entries.size() && due_count < MAX_RESULTS &&
                   pending_entries[due_count].event_time <= t) begin
               due_count++;
            end
            if (due_count == 0) begin
               w = '{KIND_NONE_DUE, '0, t, 1'b0, 1'b1};
               owed_results.insert(owed_results.size(), w);
            end
            for (int i = 0; i < due_count; i++) begin
               e = pending_entries[0];
               pending_entries.delete(0);
               w = '{KIND_RELEASED, e.handle, e.event_time, 1'b0, (i == due_count - 1)};
               owed_results.insert(owed_results.size(), w);
            end
         end
      endfunction

      function void report_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
         errors++;
      endfunction

      // Compare one accepted result word with the oldest one owed
      function void check_result(rsp_word_type got);
         rsp_word_type exp;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result word: expected none, actual %0h", $time, got);
            errors++;
            return;
         end
         exp = owed_results[0];
         owed_results.delete(0);
         if (got.kind !== exp.kind) report_field("kind", 64'(exp.kind), 64'(got.kind));
         if (got.handle !== exp.handle) begin
            report_field("handle_out", 64'(exp.handle), 64'(got.handle));
         end
         if (got.due !== exp.due) report_field("time_out", 64'(exp.due), 64'(got.due));
         if (got.became_first !== exp.became_first) begin
            report_field("became_first", 64'(exp.became_first), 64'(got.became_first));
         end
         if (got.is_last !== exp.is_last) begin
            report_field("last", 64'(exp.is_last), 64'(got.is_last));
         end
      endfunction
   endclass

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       req_cmd          = CMD_SCHEDULE;
   time_type   req_event_time   = '0;
   handle_type req_handle       = '0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [1:0] rsp_kind;
   handle_type rsp_handle_out;
   time_type   rsp_time_out;
   logic       rsp_became_first;
   logic       rsp_last;

   timer_queue_scoreboard sb = new();

   int       req_idle_pct  = 0;
   int       rsp_idle_pct  = 0;
   bit       stall_request = 1'b0;
   int       stall_left    = 0;
   int       cycle_count   = 0;
   time_type now_time;

   sorted_timer_event_queue_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_event_time   (req_event_time),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_time_out     (rsp_time_out),
      .rsp_became_first (rsp_became_first),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_timer_event_queue_top_tb: errors");
         $finish;
      end
   end

   // Receiver: random back-pressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (stall_request) begin
         stall_left    = LONG_STALL;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Monitor both channels at the edge
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_cmd, req_event_time, req_handle);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_handle_out, rsp_time_out, rsp_became_first, rsp_last};
            sb.check_result(got);
         end
      end
   end

   // Offer one word and hold it until accepted; valid stays up into the next word
   task automatic send_word(input logic cmd, input time_type t, input handle_type h);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_event_time <= t;
      req_handle     <= h;
      do @(posedge clock); while (!req_ready);
   endtask

   // One edge first so the monitor has noted the last accepted word
   task automatic drain();
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic time_type any_time();
      time_type v;
      v = {16'($urandom), 32'($urandom)};
      if (v > TIME_MAX) v = TIME_MAX;
      return v;
   endfunction

   // Fill past capacity near the current time so the full case shows up
   task automatic fill_queue();
      for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
         send_word(CMD_SCHEDULE, now_time + time_type'($urandom_range(40)), 16'($urandom));
      end
   endtask

   // Mostly schedules and ticks around a moving clock, with some wild values
   task automatic random_word();
      int       mode;
      time_type t;
      mode = $urandom_range(99);
      if (mode < 52) begin
         t = now_time + time_type'($urandom_range(6) * 5);
         send_word(CMD_SCHEDULE, t, 16'($urandom));
      end else if (mode < 82) begin
         now_time = now_time + time_type'($urandom_range(30));
         send_word(CMD_TICK, now_time, 16'($urandom));
      end else if (mode < 90) begin
         send_word(CMD_SCHEDULE, any_time(), 16'($urandom));
      end else if (mode < 96) begin
         send_word(CMD_TICK, any_time(), 16'($urandom));
      end else if (mode < 98) begin
         send_word(CMD_TICK, '0, 16'($urandom));
      end else begin
         send_word(CMD_TICK, TIME_MAX, 16'($urandom));
      end
   endtask

   initial begin
      now_time = time_type'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick, extremes, ties, partial and full release
      send_word(CMD_TICK,     '0,                16'hffff);
      send_word(CMD_SCHEDULE, TIME_MAX,          16'hffff);
      send_word(CMD_SCHEDULE, '0,                16'h0000);
      send_word(CMD_SCHEDULE, 48'd100,           16'h0001);
      send_word(CMD_SCHEDULE, 48'd100,           16'h0002);
      send_word(CMD_SCHEDULE, 48'd50,            16'h0003);
      send_word(CMD_SCHEDULE, 48'd100,           16'h0004);
      send_word(CMD_TICK,     48'd99,            16'h1234);
      send_word(CMD_TICK,     48'd100,           16'h0000);
      send_word(CMD_TICK,     TIME_MAX - 1,      16'h0000);
      send_word(CMD_TICK,     TIME_MAX,          16'h0000);
      send_word(CMD_SCHEDULE, 48'h5555_5555_5555, 16'haaaa);
      send_word(CMD_SCHEDULE, 48'haaaa_aaaa_aaaa, 16'h5555);
      send_word(CMD_SCHEDULE, 48'haaaa_aaaa_aaaa, 16'h0ff0);
      send_word(CMD_TICK,     TIME_MAX,          16'h0000);
      req_valid <= 1'b0;
      drain();

      // Random phases: sender/receiver idling swapped, then none at all
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 57 : 0;
         rsp_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 27 : 0;
         fill_queue();
         for (int i = 0; i < PHASE_WORDS; i++) begin
            random_word();
            // long receiver hold-off while words keep coming
            if (phase == 0 && i == PHASE_WORDS / 2) begin
               stall_request = 1'b1;
               for (int j = 0; j < 12; j++) begin
                  send_word(CMD_SCHEDULE, now_time + time_type'($urandom_range(40)),
                            16'($urandom));
               end
            end
            // sender waits for every owed result now and then
            if (i == PHASE_WORDS * 3 / 4) begin
               req_valid <= 1'b0;
               drain();
            end
         end
         req_valid <= 1'b0;
         drain();
      end

      // A final sweep empties whatever is left
      send_word(CMD_TICK, TIME_MAX, 16'($urandom));
      req_valid <= 1'b0;
      drain();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("sorted_timer_event_queue_top_tb: clean");
      end else begin
         $display("sorted_timer_event_queue_top_tb: errors");
      end
      $finish;
   end

endmodule
